### rtl/fret_efficiency_error_propagation_assert.svh
// Assertion macros for the FRET efficiency error propagation block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef FRET_EFFICIENCY_ERROR_PROPAGATION_ASSERT_SVH
`define FRET_EFFICIENCY_ERROR_PROPAGATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FEEP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FEEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FEEP_ASSERT(lbl, prop, msg)
`define FEEP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/feep_pkg.sv
// Shared constants, register codes and helpers for the FRET error datapath.
// No dependencies.
`default_nettype none
package feep_pkg;

    localparam int Q_FRAC     = 16;
    localparam int DATA_W     = 32;
    localparam int OUT_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int MUL_CHUNK  = 24;
    localparam int MUL_LAT    = 4;
    localparam int RSS_ROOT_W = 32;
    localparam int RSS_LAT    = RSS_ROOT_W + 3;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;
    localparam logic [OUT_W-1:0] Q_ONE   = OUT_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAMMA       = 2'd0,
        REG_SIGMA_GAMMA = 2'd1,
        REG_SIGMA_ALPHA = 2'd2,
        REG_SIGMA_DELTA = 2'd3
    } cfg_reg_t;

    function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

endpackage
`default_nettype wire

### rtl/feep_delay.sv
// Enabled shift line that aligns side values with the long datapath.
// No dependencies.
`default_nettype none
module feep_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule
`default_nettype wire

### rtl/feep_div.sv
// Pipelined restoring divider, one quotient bit per stage, N_W stages.
// Depends on nothing; divisor must be nonzero.
`default_nettype none
module feep_div #(
    parameter int N_W = 32,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           en,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [N_W-1:0] quotient
);

    logic [D_W-1:0] rem_reg [N_W];
    logic [N_W-1:0] nq_reg  [N_W];
    logic [D_W-1:0] dv_reg  [N_W];

    for (genvar i = 0; i < N_W; i++)
    begin : g_step
        logic [D_W-1:0] rem_in;
        logic [N_W-1:0] nq_in;
        logic [D_W-1:0] dv_in;
        logic [D_W:0]   trial;
        logic           fits;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign nq_in  = dividend;
            assign dv_in  = divisor;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign dv_in  = dv_reg[i-1];
        end

        assign trial = {rem_in, nq_in[N_W-1]};
        assign fits  = trial >= {1'b0, dv_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= fits ? D_W'(trial - {1'b0, dv_in}) : trial[D_W-1:0];
                nq_reg[i]  <= {nq_in[N_W-2:0], fits};
                dv_reg[i]  <= dv_in;
            end
        end
    end

    assign quotient = nq_reg[N_W-1];

endmodule
`default_nettype wire

### rtl/feep_mul.sv
// Pipelined Q15.16 multiply from 24-bit partial products, result saturated to O_W bits.
// Depends on feep_pkg.
`default_nettype none
module feep_mul
    import feep_pkg::*;
#(
    parameter int A_W = 32,
    parameter int B_W = 32,
    parameter int O_W = 31
) (
    input  logic           clk,
    input  logic           en,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic [O_W-1:0] result
);

    localparam int NA = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PW = A_W + B_W;

    logic [NA*MUL_CHUNK-1:0] a_ext;
    logic [NB*MUL_CHUNK-1:0] b_ext;
    logic [2*MUL_CHUNK-1:0]  pp_reg [NA][NB];
    logic [PW-1:0]           row_next [NA];
    logic [PW-1:0]           row_reg  [NA];
    logic [PW-1:0]           sum_next;
    logic [PW-1:0]           sum_reg;
    logic [O_W-1:0]          res_next;
    logic [O_W-1:0]          res_reg;

    assign a_ext = (NA*MUL_CHUNK)'(a);
    assign b_ext = (NB*MUL_CHUNK)'(b);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) << (j*MUL_CHUNK));
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            sum_next = sum_next + (row_reg[i] << (i*MUL_CHUNK));
        end
    end

    assign res_next = (|sum_reg[PW-1:Q_FRAC+O_W]) ? '1 : sum_reg[Q_FRAC+O_W-1:Q_FRAC];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_ext[i*MUL_CHUNK +: MUL_CHUNK]
                                  * b_ext[j*MUL_CHUNK +: MUL_CHUNK];
                end
                row_reg[i] <= row_next[i];
            end
            sum_reg <= sum_next;
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule
`default_nettype wire

### rtl/feep_rss.sv
// Pipelined root-sum-square of three Q15.16 values: square, sum,
// digit-by-digit square root, saturate. Depends on feep_pkg.
`default_nettype none
module feep_rss
    import feep_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [OUT_W-1:0] a,
    input  logic [OUT_W-1:0] b,
    input  logic [OUT_W-1:0] c,
    output logic [OUT_W-1:0] result
);

    localparam int R_W = RSS_ROOT_W;
    localparam int X_W = 2 * RSS_ROOT_W;

    logic [2*OUT_W-1:0] sqa_reg, sqb_reg, sqc_reg;
    logic [X_W-1:0]     sum_reg;
    logic [R_W+1:0]     rem_reg  [R_W];
    logic [R_W-1:0]     root_reg [R_W];
    logic [X_W-1:0]     x_reg    [R_W];
    logic [OUT_W-1:0]   res_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqa_reg <= a * a;
            sqb_reg <= b * b;
            sqc_reg <= c * c;
            sum_reg <= X_W'(sqa_reg) + X_W'(sqb_reg) + X_W'(sqc_reg);
        end
    end

    for (genvar k = 0; k < R_W; k++)
    begin : g_root
        logic [R_W+1:0] rem_in;
        logic [R_W-1:0] root_in;
        logic [X_W-1:0] x_in;
        logic [R_W+3:0] cur;
        logic [R_W+3:0] trial;
        logic           fits;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = sum_reg;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
        end

        assign cur   = {rem_in, x_in[X_W-1:X_W-2]};
        assign trial = (R_W+4)'({root_in, 2'b01});
        assign fits  = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fits ? (R_W+2)'(cur - trial) : cur[R_W+1:0];
                root_reg[k] <= {root_in[R_W-2:0], fits};
                x_reg[k]    <= {x_in[X_W-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= (|root_reg[R_W-1][R_W-1:OUT_W]) ? OUT_MAX
                                                       : root_reg[R_W-1][OUT_W-1:0];
        end
    end

    assign result = res_reg;

endmodule
`default_nettype wire

### rtl/fret_efficiency_error_propagation.sv
// Top level: FRET efficiency error propagation pipeline with config registers.
// Depends on feep_pkg, feep_delay, feep_div, feep_mul, feep_rss and the assert header.
//
// Channel  Dir  Handshake             Payload
// cfg      in   cfg_write             cfg_index, cfg_data
// in       in   in_valid / in_ready   efficiency .. stat_present
// out      out  out_valid / out_ready total_error .. delta_term
//
// One burst per cycle while the skid stage is empty.
// Latency is set by the delta path: two dividers (48 and 64 steps), two
// multipliers, then two 32-step square roots in series.
// Reset loads gamma 1.0 and zero sigmas and clears all valid bits.
// A result not taken goes to a skid stage; the pipeline holds until it drains.
`default_nettype none
`include "fret_efficiency_error_propagation_assert.svh"
module fret_efficiency_error_propagation
    import feep_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [OUT_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [DATA_W-1:0] efficiency,
    input  logic signed [DATA_W-1:0] donor_signal,
    input  logic signed [DATA_W-1:0] acceptor_signal,
    input  logic                  acceptor_present,
    input  logic signed [DATA_W-1:0] stat_error,
    input  logic                  stat_present,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_W-1:0]      total_error,
    output logic [OUT_W-1:0]      systematic_error,
    output logic [OUT_W-1:0]      statistical_error,
    output logic [OUT_W-1:0]      gamma_term,
    output logic [OUT_W-1:0]      alpha_term,
    output logic [OUT_W-1:0]      delta_term
);

    localparam int P_W   = 2*DATA_W - Q_FRAC - 1;
    localparam int QG_N  = P_W + Q_FRAC;
    localparam int R1_N  = DATA_W + Q_FRAC;
    localparam int R2_N  = R1_N + Q_FRAC;
    localparam int M_W   = R1_N;
    localparam int T_IN  = 1;
    localparam int T_S   = 2;
    localparam int T_GT  = T_S + QG_N + MUL_LAT;
    localparam int T_R2  = T_IN + R1_N + R2_N;
    localparam int T_DT  = T_R2 + 2*MUL_LAT;
    localparam int T_SYS = T_DT + RSS_LAT;
    localparam int T_TOT = T_SYS + RSS_LAT;

    typedef struct packed {
        logic [OUT_W-1:0] total;
        logic [OUT_W-1:0] sys;
        logic [OUT_W-1:0] stat;
        logic [OUT_W-1:0] gt;
        logic [OUT_W-1:0] at;
        logic [OUT_W-1:0] dt;
    } result_t;

    logic [OUT_W-1:0] gamma_reg, sg_reg, sa_reg, sd_reg;
    logic [OUT_W-1:0] g_eff;
    logic             en;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= Q_ONE;
            sg_reg    <= '0;
            sa_reg    <= '0;
            sd_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAMMA:       gamma_reg <= cfg_data;
                REG_SIGMA_GAMMA: sg_reg    <= cfg_data;
                REG_SIGMA_ALPHA: sa_reg    <= cfg_data;
                REG_SIGMA_DELTA: sd_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign g_eff = (gamma_reg == '0) ? Q_ONE : gamma_reg;

    // stage 1: magnitudes
    logic [DATA_W:0]    om_w;
    logic [DATA_W-1:0]  aom_next, dd_mag, st_mag;
    logic               dz_next;
    logic [OUT_W-1:0]   stat_next;
    logic [DATA_W-1:0]  ae_reg, aom_reg, aa_reg, dd_reg;
    logic               dz_reg;
    logic [OUT_W-1:0]   stat_reg;

    assign om_w     = (DATA_W+1)'(Q_ONE) - {efficiency[DATA_W-1], efficiency};
    assign aom_next = om_w[DATA_W] ? DATA_W'(~om_w + (DATA_W+1)'(1)) : om_w[DATA_W-1:0];
    assign dz_next  = !acceptor_present || (donor_signal == '0);
    assign dd_mag   = mag_of(donor_signal);
    assign st_mag   = mag_of(stat_error);
    assign stat_next = !stat_present ? '0
                     : (st_mag[DATA_W-1] ? OUT_MAX : st_mag[OUT_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ae_reg   <= mag_of(efficiency);
            aom_reg  <= aom_next;
            aa_reg   <= mag_of(acceptor_signal);
            dd_reg   <= (donor_signal == '0) ? DATA_W'(1) : dd_mag;
            dz_reg   <= dz_next;
            stat_reg <= stat_next;
        end
    end

    // stage 2: E*(1-E) and (1-E)^2
    logic [2*DATA_W-1:0] pe_prod, ps_prod;
    logic [P_W-1:0]      p_reg, s_reg;

    assign pe_prod = ae_reg * aom_reg;
    assign ps_prod = aom_reg * aom_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= pe_prod[Q_FRAC+P_W-1:Q_FRAC];
            s_reg <= ps_prod[Q_FRAC+P_W-1:Q_FRAC];
        end
    end

    // gamma and alpha paths
    logic [QG_N-1:0]  qg, qa;
    logic [OUT_W-1:0] gt, at, gt_d, at_d;

    feep_div #(.N_W(QG_N), .D_W(OUT_W)) u_div_g (
        .clk(clk), .en(en), .dividend({p_reg, {Q_FRAC{1'b0}}}), .divisor(g_eff), .quotient(qg)
    );
    feep_div #(.N_W(QG_N), .D_W(OUT_W)) u_div_a (
        .clk(clk), .en(en), .dividend({s_reg, {Q_FRAC{1'b0}}}), .divisor(g_eff), .quotient(qa)
    );
    feep_mul #(.A_W(QG_N), .B_W(OUT_W), .O_W(OUT_W)) u_mul_g (
        .clk(clk), .en(en), .a(qg), .b(sg_reg), .result(gt)
    );
    feep_mul #(.A_W(QG_N), .B_W(OUT_W), .O_W(OUT_W)) u_mul_a (
        .clk(clk), .en(en), .a(qa), .b(sa_reg), .result(at)
    );
    feep_delay #(.WIDTH(2*OUT_W), .DEPTH(T_DT - T_GT)) u_dly_ga (
        .clk(clk), .en(en), .din({gt, at}), .dout({gt_d, at_d})
    );

    // delta path
    logic [R1_N-1:0]  r1;
    logic [R2_N-1:0]  r2;
    logic [P_W-1:0]   s_d;
    logic [M_W-1:0]   m;
    logic [OUT_W-1:0] dt, dt_f;
    logic             dz_d;

    feep_div #(.N_W(R1_N), .D_W(DATA_W)) u_div_r1 (
        .clk(clk), .en(en), .dividend({aa_reg, {Q_FRAC{1'b0}}}), .divisor(dd_reg), .quotient(r1)
    );
    feep_div #(.N_W(R2_N), .D_W(OUT_W)) u_div_r2 (
        .clk(clk), .en(en), .dividend({r1, {Q_FRAC{1'b0}}}), .divisor(g_eff), .quotient(r2)
    );
    feep_delay #(.WIDTH(P_W), .DEPTH(T_R2 - T_S)) u_dly_s (
        .clk(clk), .en(en), .din(s_reg), .dout(s_d)
    );
    feep_mul #(.A_W(R2_N), .B_W(P_W), .O_W(M_W)) u_mul_m (
        .clk(clk), .en(en), .a(r2), .b(s_d), .result(m)
    );
    feep_mul #(.A_W(M_W), .B_W(OUT_W), .O_W(OUT_W)) u_mul_d (
        .clk(clk), .en(en), .a(m), .b(sd_reg), .result(dt)
    );
    feep_delay #(.WIDTH(1), .DEPTH(T_DT - T_IN)) u_dly_dz (
        .clk(clk), .en(en), .din(dz_reg), .dout(dz_d)
    );

    assign dt_f = dz_d ? '0 : dt;

    // root-sum-square stages
    logic [OUT_W-1:0] sys, stat_d, tot, sys_o, stat_o;
    logic [OUT_W-1:0] gt_o, at_o, dt_o;

    feep_delay #(.WIDTH(OUT_W), .DEPTH(T_SYS - T_IN)) u_dly_stat (
        .clk(clk), .en(en), .din(stat_reg), .dout(stat_d)
    );
    feep_rss u_rss_sys (
        .clk(clk), .en(en), .a(gt_d), .b(at_d), .c(dt_f), .result(sys)
    );
    feep_rss u_rss_tot (
        .clk(clk), .en(en), .a(sys), .b(stat_d), .c('0), .result(tot)
    );
    feep_delay #(.WIDTH(2*OUT_W), .DEPTH(T_TOT - T_SYS)) u_dly_ss (
        .clk(clk), .en(en), .din({sys, stat_d}), .dout({sys_o, stat_o})
    );
    feep_delay #(.WIDTH(3*OUT_W), .DEPTH(T_TOT - T_DT)) u_dly_terms (
        .clk(clk), .en(en), .din({gt_d, at_d, dt_f}), .dout({gt_o, at_o, dt_o})
    );

    // valid bits and output skid
    logic [T_TOT-1:0] vld_reg;
    logic             tail_valid;
    result_t          tail, sk_reg, res;
    logic             sk_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[T_TOT-2:0], in_valid};
        end
    end

    assign tail_valid = vld_reg[T_TOT-1];
    assign tail = '{total: tot, sys: sys_o, stat: stat_o, gt: gt_o, at: at_o, dt: dt_o};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sk_valid_reg <= 1'b0;
        end
        else if (!sk_valid_reg)
        begin
            sk_valid_reg <= tail_valid && !out_ready;
        end
        else if (out_ready)
        begin
            sk_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sk_valid_reg)
        begin
            sk_reg <= tail;
        end
    end

    assign en        = !sk_valid_reg;
    assign in_ready  = en;
    assign out_valid = sk_valid_reg || tail_valid;
    assign res       = sk_valid_reg ? sk_reg : tail;

    assign total_error       = res.total;
    assign systematic_error  = res.sys;
    assign statistical_error = res.stat;
    assign gamma_term        = res.gt;
    assign alpha_term        = res.at;
    assign delta_term        = res.dt;

    `FEEP_ASSERT_NEXT(a_hold, sk_valid_reg && !out_ready, $stable(vld_reg), "pipeline moved while skid full")
    `FEEP_ASSERT(a_skid_src, $rose(sk_valid_reg) |-> $past(tail_valid), "skid loaded from empty tail")
    `FEEP_ASSERT(a_sys_ge, out_valid |-> (systematic_error >= gamma_term && systematic_error >= alpha_term && systematic_error >= delta_term), "systematic below a term")
    `FEEP_ASSERT(a_tot_ge, out_valid |-> (total_error >= systematic_error && total_error >= statistical_error), "total below a component")

endmodule
`default_nettype wire
